### src/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared constants and state encoding for the quicksort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qse_pkg;

    localparam int CAPACITY      = 64;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = ADDR_W + 1;
    // larger side is pushed, so depth never exceeds log2 of the set size
    localparam int STACK_SLOTS   = ADDR_W + 1;
    localparam int DEPTH_W       = $clog2(STACK_SLOTS + 1);
    localparam int STACK_ENTRY_W = 2 * ADDR_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BEGIN,
        ST_RD_MID,
        ST_RD_LO,
        ST_SW1,
        ST_SW2,
        ST_FETCH_I,
        ST_CHK_I,
        ST_FETCH_J,
        ST_CHK_J,
        ST_SWAP,
        ST_FIN_RD,
        ST_FIN_WR1,
        ST_FIN_WR2,
        ST_NEXT,
        ST_E_RD,
        ST_E_LOAD
    } qse_state_t;

endpackage

`default_nettype wire

### src/quicksort_engine_core.sv
// ----------------------------------------------------------------------------
// quicksort_engine_core
// Collects signed items into a local store, sorts them in place by quicksort
// (middle pivot, two-pointer partition) and streams them out in order.
// ----------------------------------------------------------------------------
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------
//  item    | item_valid / item_ready     | value[31:0] (signed), last
//  result  | result_valid / result_ready | sorted_value[31:0], final_res,
//          |                             | overflow
//
//  Loading accepts one item per cycle. The sort is bound by the single read
//  port of the element store: a range is set up by reading and swapping the
//  middle and low elements, a pointer step is a fetch and a check, a swap is
//  the two failed checks plus the write-back, and a pass ends by placing the
//  pivot and choosing the next range. Reset clears all control state; the
//  store needs no clearing pass. A stalled result holds the sequencer, but
//  the last result of a set may wait while the next set is loaded.
//
`default_nettype none

module quicksort_engine_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic signed [qse_pkg::DATA_W-1:0] value,
    input  wire logic                        last,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic signed [qse_pkg::DATA_W-1:0] sorted_value,
    output logic                             final_res,
    output logic                             overflow
);

    localparam int AW = qse_pkg::ADDR_W;
    localparam int CW = qse_pkg::CNT_W;
    localparam int DW = qse_pkg::DATA_W;
    localparam int SW = qse_pkg::STACK_ENTRY_W;

    qse_pkg::qse_state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic                   dropped_reg, dropped_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [CW-1:0]          i_reg, i_next;     // may run one past hi
    logic [AW-1:0]          j_reg, j_next;
    logic [qse_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [AW-1:0]          k_reg, k_next;
    logic                   result_valid_reg, result_valid_next;

    logic signed [DW-1:0]   pivot_reg, pivot_next;
    logic [DW-1:0]          ai_reg, ai_next;
    logic [SW-1:0]          stack_reg [qse_pkg::STACK_SLOTS];
    logic signed [DW-1:0]   sorted_value_reg;
    logic                   final_res_reg;
    logic                   overflow_reg;

    logic                   push_en;
    logic [SW-1:0]          push_entry;
    logic                   res_load;
    logic                   res_final;

    // element store ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DW-1:0]          ram_rdata;

    qse_ram #(
        .WIDTH (DW),
        .DEPTH (qse_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // helpers
    logic [AW:0]   lo_hi_sum;
    logic [AW-1:0] mid;
    logic [AW-1:0] len1, len2;
    logic          do_l, do_r;
    logic          i_ge_j;
    logic          out_free;
    logic [SW-1:0] pop_entry;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[AW:1];
    assign len1      = j_reg - lo_reg;
    assign len2      = hi_reg - j_reg;
    assign do_l      = len1 > AW'(1);
    assign do_r      = len2 > AW'(1);
    assign i_ge_j    = i_reg >= {1'b0, j_reg};
    assign out_free  = !result_valid_reg || result_ready;
    assign pop_entry = stack_reg[depth_reg - qse_pkg::DEPTH_W'(1)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= qse_pkg::ST_IDLE;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            depth_reg        <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            depth_reg        <= depth_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pivot_reg <= pivot_next;
        ai_reg    <= ai_next;
        if (push_en)
        begin
            stack_reg[depth_reg] <= push_entry;
        end
        if (res_load)
        begin
            sorted_value_reg <= $signed(ram_rdata);
            final_res_reg    <= res_final;
            overflow_reg     <= dropped_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        depth_next        = depth_reg;
        k_next            = k_reg;
        pivot_next        = pivot_reg;
        ai_next           = ai_reg;
        result_valid_next = result_valid_reg && !result_ready;
        push_en           = 1'b0;
        push_entry        = {lo_reg, hi_reg};
        res_load          = 1'b0;
        res_final         = (CW'(k_reg) + CW'(1)) == count_reg;
        item_ready        = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = lo_reg;
        ram_wdata         = pivot_reg;
        ram_raddr         = lo_reg;

        unique case (state_reg)
            qse_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (count_reg < CW'(qse_pkg::CAPACITY))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = qse_pkg::ST_BEGIN;
                    end
                end
            end

            qse_pkg::ST_BEGIN:
            begin
                depth_next = '0;
                k_next     = '0;
                if (count_reg >= CW'(2))
                begin
                    lo_next    = '0;
                    hi_next    = AW'(count_reg - CW'(1));
                    state_next = qse_pkg::ST_RD_MID;
                end
                else if (count_reg == '0)
                begin
                    dropped_next = 1'b0;
                    state_next   = qse_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = qse_pkg::ST_E_RD;
                end
            end

            qse_pkg::ST_RD_MID:
            begin
                ram_raddr  = mid;
                state_next = qse_pkg::ST_RD_LO;
            end

            qse_pkg::ST_RD_LO:
            begin
                pivot_next = $signed(ram_rdata);
                ram_raddr  = lo_reg;
                state_next = qse_pkg::ST_SW1;
            end

            // move the low element to the middle, pivot to the low end
            qse_pkg::ST_SW1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = mid;
                ram_wdata  = ram_rdata;
                state_next = qse_pkg::ST_SW2;
            end

            qse_pkg::ST_SW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = pivot_reg;
                i_next     = CW'(lo_reg) + CW'(1);
                j_next     = hi_reg;
                state_next = qse_pkg::ST_FETCH_I;
            end

            qse_pkg::ST_FETCH_I:
            begin
                ram_raddr  = i_reg[AW-1:0];
                state_next = qse_pkg::ST_CHK_I;
            end

            qse_pkg::ST_CHK_I:
            begin
                if ($signed(ram_rdata) <= pivot_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = i_ge_j ? qse_pkg::ST_FIN_RD : qse_pkg::ST_FETCH_I;
                end
                else
                begin
                    ai_next    = ram_rdata;
                    state_next = qse_pkg::ST_FETCH_J;
                end
            end

            qse_pkg::ST_FETCH_J:
            begin
                ram_raddr  = j_reg;
                state_next = qse_pkg::ST_CHK_J;
            end

            qse_pkg::ST_CHK_J:
            begin
                if ($signed(ram_rdata) > pivot_reg)
                begin
                    j_next     = j_reg - AW'(1);
                    state_next = i_ge_j ? qse_pkg::ST_FIN_RD : qse_pkg::ST_FETCH_J;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = i_reg[AW-1:0];
                    ram_wdata  = ram_rdata;
                    state_next = qse_pkg::ST_SWAP;
                end
            end

            qse_pkg::ST_SWAP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = ai_reg;
                i_next     = i_reg + CW'(1);
                state_next = i_ge_j ? qse_pkg::ST_FIN_RD : qse_pkg::ST_FETCH_I;
            end

            // pivot into its final place at j (no-op when j is the base)
            qse_pkg::ST_FIN_RD:
            begin
                ram_raddr  = j_reg;
                state_next = qse_pkg::ST_FIN_WR1;
            end

            qse_pkg::ST_FIN_WR1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = qse_pkg::ST_FIN_WR2;
            end

            qse_pkg::ST_FIN_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = pivot_reg;
                state_next = qse_pkg::ST_NEXT;
            end

            qse_pkg::ST_NEXT:
            begin
                state_next = qse_pkg::ST_RD_MID;
                if (do_l && do_r)
                begin
                    push_en = depth_reg < qse_pkg::DEPTH_W'(qse_pkg::STACK_SLOTS);
                    if (push_en)
                    begin
                        depth_next = depth_reg + qse_pkg::DEPTH_W'(1);
                    end
                    // ties go to the low side as the larger
                    if (len1 >= len2)
                    begin
                        push_entry = {lo_reg, j_reg - AW'(1)};
                        lo_next    = j_reg + AW'(1);
                    end
                    else
                    begin
                        push_entry = {j_reg + AW'(1), hi_reg};
                        hi_next    = j_reg - AW'(1);
                    end
                end
                else if (do_l)
                begin
                    hi_next = j_reg - AW'(1);
                end
                else if (do_r)
                begin
                    lo_next = j_reg + AW'(1);
                end
                else if (depth_reg != '0)
                begin
                    depth_next = depth_reg - qse_pkg::DEPTH_W'(1);
                    lo_next    = pop_entry[SW-1:AW];
                    hi_next    = pop_entry[AW-1:0];
                end
                else
                begin
                    k_next     = '0;
                    state_next = qse_pkg::ST_E_RD;
                end
            end

            qse_pkg::ST_E_RD:
            begin
                ram_raddr  = k_reg;
                state_next = qse_pkg::ST_E_LOAD;
            end

            qse_pkg::ST_E_LOAD:
            begin
                ram_raddr = k_reg;
                if (out_free)
                begin
                    res_load          = 1'b1;
                    result_valid_next = 1'b1;
                    if (res_final)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        depth_next   = '0;
                        state_next   = qse_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = qse_pkg::ST_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = qse_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign final_res    = final_res_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

### src/qse_ram.sv
// ----------------------------------------------------------------------------
// qse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quicksort_engine_core: sets of signed items are
// loaded, the expected ascending order is worked out alongside, and every
// result is compared field by field as it leaves the engine.
// ----------------------------------------------------------------------------

module testbench;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 260;
    // worst-case sort of a full store plus long result stalls, with margin
    localparam int IDLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES  = 200;

    typedef logic signed [qse_pkg::DATA_W-1:0] elem_t;

    typedef struct {
        elem_t value;
        logic  is_final;
        logic  dropped;
    } sorted_item_t;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    elem_t value        = '0;
    logic  last         = 1'b0;
    logic  result_ready = 1'b0;

    wire logic  item_ready;
    wire logic  result_valid;
    wire elem_t sorted_value;
    wire logic  final_res;
    wire logic  overflow;

    // shadow of the set being loaded, and the results still owed by the engine
    elem_t        load_set[$];
    bit           load_dropped = 1'b0;
    sorted_item_t sorted_expect[$];

    int error_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    logic [15:0] ready_pattern = 16'hFFFF;

    quicksort_engine_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Expected behaviour: append while there is room, otherwise note the drop.
    // On a last item the stored set leaves in ascending signed order; ties are
    // indistinguishable so any stable order of equal values is the same.
    // ------------------------------------------------------------------------
    function automatic void record_item(input elem_t v, input logic is_last);
        elem_t        ordered[$];
        elem_t        key;
        int           j;
        sorted_item_t entry;
        if (load_set.size() < qse_pkg::CAPACITY)
            load_set.push_back(v);
        else
            load_dropped = 1'b1;
        if (is_last)
        begin
            ordered = load_set;
            for (int i = 1; i < ordered.size(); i++)
            begin
                key = ordered[i];
                j   = i - 1;
                while (j >= 0 && ordered[j] > key)
                begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = key;
            end
            foreach (ordered[k])
            begin
                entry.value    = ordered[k];
                entry.is_final = (k == ordered.size() - 1);
                entry.dropped  = load_dropped;
                sorted_expect.push_back(entry);
            end
            load_set.delete();
            load_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Valid stays
    // up across back-to-back items, so it is only lowered when a gap is due.
    // ------------------------------------------------------------------------
    task automatic send_item(input elem_t v, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        value      <= v;
        last       <= is_last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        record_item(v, is_last);
        items_sent++;
    endtask

    // flavours: narrow range (many ties), extremes, near the limits, full range
    function automatic elem_t pick_value(input int flavour);
        case (flavour)
            0: return elem_t'($urandom_range(0, 15) - 8);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return elem_t'(32'h8000_0000);
                    1:       return elem_t'(32'h7FFF_FFFF);
                    2:       return elem_t'(0);
                    default: return elem_t'(-1);
                endcase
            end
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                    return elem_t'(32'h8000_0000 + $urandom_range(0, 7));
                return elem_t'(32'h7FFF_FFFF - $urandom_range(0, 7));
            end
            default: return elem_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: ready follows a rotating pattern that is now and then swapped
    // for another, giving stretches of full rate, long stalls and chatter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ($urandom_range(0, 47) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'h0001;
                2:       ready_pattern <= 16'h5555;
                default: ready_pattern <= 16'($urandom);
            endcase
        end
        else
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        result_ready <= ready_pattern[0];
    end

    // result checker
    always @(posedge clk)
    begin
        sorted_item_t exp_item;
        if (rst_n && result_valid && result_ready)
        begin
            if (sorted_expect.size() == 0)
            begin
                $error("result with nothing expected: sorted_value %0d", sorted_value);
                error_count++;
            end
            else
            begin
                exp_item = sorted_expect.pop_front();
                if (sorted_value !== exp_item.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           exp_item.value, sorted_value);
                    error_count++;
                end
                if (final_res !== exp_item.is_final)
                begin
                    $error("final_res: expected %0b, actual %0b",
                           exp_item.is_final, final_res);
                    error_count++;
                end
                if (overflow !== exp_item.dropped)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           exp_item.dropped, overflow);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_element();
        send_item(elem_t'(32'h8000_0000), 1'b1);
    endtask

    task automatic test_extremes();
        send_item(elem_t'(32'h7FFF_FFFF), 1'b0);
        send_item(elem_t'(32'h8000_0000), 1'b0);
        send_item(elem_t'(0), 1'b0);
        send_item(elem_t'(-1), 1'b0);
        send_item(elem_t'(1), 1'b0);
        send_item(elem_t'(32'h7FFF_FFFF), 1'b0);
        send_item(elem_t'(32'h8000_0000), 1'b1);
    endtask

    // every element equals the pivot, so all of them stay on the low side
    task automatic test_equal_values();
        for (int k = 0; k < 6; k++)
            send_item(elem_t'(-5), k == 5);
    endtask

    task automatic test_presorted();
        for (int k = 0; k < 5; k++)
            send_item(elem_t'(k * 3 - 4), k == 4);
        for (int k = 0; k < 5; k++)
            send_item(elem_t'(100 - k * 7), k == 4);
    endtask

    // a set that just fits, then one whose last item is itself dropped
    task automatic test_store_full();
        for (int k = 0; k < qse_pkg::CAPACITY; k++)
            send_item(pick_value(3), k == qse_pkg::CAPACITY - 1);
        for (int k = 0; k < qse_pkg::CAPACITY + 2; k++)
            send_item(pick_value(k % 4), k == qse_pkg::CAPACITY + 1);
    endtask

    // mostly short sets; a few large ones up to full size and a few that overflow
    task automatic test_random_sets();
        int target;
        int roll;
        int set_len;
        int flavour;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                set_len = $urandom_range(1, 12);
            else if (roll < 88)
                set_len = $urandom_range(13, 40);
            else if (roll < 97)
                set_len = $urandom_range(41, qse_pkg::CAPACITY);
            else
                set_len = $urandom_range(qse_pkg::CAPACITY + 1, qse_pkg::CAPACITY + 6);
            flavour = $urandom_range(0, 5);
            for (int k = 0; k < set_len; k++)
                send_item(pick_value(flavour), k == set_len - 1);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_single_element();
        test_extremes();
        test_equal_values();
        test_presorted();
        test_store_full();
        test_random_sets();

        item_valid <= 1'b0;
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && sorted_expect.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
